[rtl/biou_pkg.sv]
// ----------------------------------------------------------------------------
// biou_pkg - box overlap ratio shared definitions
// Field widths, internal widths, pipeline depth and stage payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package biou_pkg;

  localparam int COORD_W   = 14;               // signed corner coordinate
  localparam int SIZE_W    = 13;               // unsigned width or height
  localparam int EXT_W     = SIZE_W;           // clamped overlap extent
  localparam int AREA_W    = 2 * SIZE_W;       // one box area
  localparam int UNION_W   = AREA_W + 1;       // sum of two areas
  localparam int SHIFT_W   = UNION_W + 1;      // shifted divider remainder
  localparam int FRAC_W    = 16;               // Q0.16 fraction bits
  localparam int RATIO_W   = FRAC_W + 1;       // ratio 0..1.0 inclusive
  localparam int EDGE_W    = COORD_W + 1;      // corner plus size
  localparam int DIFF_W    = EDGE_W + 1;       // edge difference

  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << FRAC_W;

  localparam int GEOM_STAGES = 3;
  localparam int DIV_STAGES  = RATIO_W;
  localparam int LATENCY     = GEOM_STAGES + DIV_STAGES + 1;

  // geometry front end to divider
  typedef struct packed {
    logic [AREA_W-1:0]  inter;
    logic [UNION_W-1:0] uni;
    logic               empty;
  } biou_area_t;

  // one divider stage
  typedef struct packed {
    logic [UNION_W-1:0] rem;
    logic [UNION_W-1:0] uni;
    logic [RATIO_W-1:0] quo;
    logic               empty;
  } biou_div_t;

endpackage

`default_nettype wire

[rtl/box_iou_top.sv]
// ----------------------------------------------------------------------------
// box_iou_top - intersection over union of two axis-aligned boxes
// Takes one box pair per transfer and returns the Q1.16 overlap ratio.
// ----------------------------------------------------------------------------
// A box pair is taken at every clock edge with start high; busy is always
// low, so a new pair may follow in every cycle. Each pair gives one result,
// shown for one cycle with done high, once the overlap extents, the area
// products and the union have been registered, the divider stages have
// found one quotient bit per stage, and the output register has taken the
// result. overlap_ratio is floor(65536 * intersection / union),
// 65536 meaning full overlap. When both boxes have zero area,
// union_empty is high and overlap_ratio is zero. The receiver cannot hold
// results off; results leave in the order the pairs came in.
`default_nettype none

module box_iou_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [biou_pkg::COORD_W-1:0]  first_left,
  input  wire logic [biou_pkg::COORD_W-1:0]  first_top,
  input  wire logic [biou_pkg::SIZE_W-1:0]   first_width,
  input  wire logic [biou_pkg::SIZE_W-1:0]   first_height,
  input  wire logic [biou_pkg::COORD_W-1:0]  second_left,
  input  wire logic [biou_pkg::COORD_W-1:0]  second_top,
  input  wire logic [biou_pkg::SIZE_W-1:0]   second_width,
  input  wire logic [biou_pkg::SIZE_W-1:0]   second_height,
  output logic                               done,
  output logic [biou_pkg::RATIO_W-1:0]       overlap_ratio,
  output logic                               union_empty
);
  import biou_pkg::*;

  logic               accept;
  logic               geom_valid;
  biou_area_t         geom_area;
  logic               div_valid;
  logic [RATIO_W-1:0] div_quo;
  logic               div_empty;

  // the pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  biou_geom u_geom (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (accept),
    .first_left   (first_left),
    .first_top    (first_top),
    .first_width  (first_width),
    .first_height (first_height),
    .second_left  (second_left),
    .second_top   (second_top),
    .second_width (second_width),
    .second_height(second_height),
    .out_valid    (geom_valid),
    .out_area     (geom_area)
  );

  biou_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (geom_valid),
    .in_area  (geom_area),
    .out_valid(div_valid),
    .out_quo  (div_quo),
    .out_empty(div_empty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_valid;
    end
    // drop the meaningless quotient of a zero union
    overlap_ratio <= div_empty ? '0 : div_quo;
    union_empty   <= div_empty;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("transfer did not produce a result on time");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    done && union_empty |-> overlap_ratio == '0)
    else $error("empty union with nonzero ratio");

  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    done |-> overlap_ratio <= RATIO_ONE)
    else $error("ratio above one");

endmodule

`default_nettype wire

[rtl/biou_geom.sv]
// ----------------------------------------------------------------------------
// biou_geom - intersection and union areas
// Three stages: overlap extents, area products, union sum.
// ----------------------------------------------------------------------------
`default_nettype none

module biou_geom (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [biou_pkg::COORD_W-1:0]  first_left,
  input  wire logic [biou_pkg::COORD_W-1:0]  first_top,
  input  wire logic [biou_pkg::SIZE_W-1:0]   first_width,
  input  wire logic [biou_pkg::SIZE_W-1:0]   first_height,
  input  wire logic [biou_pkg::COORD_W-1:0]  second_left,
  input  wire logic [biou_pkg::COORD_W-1:0]  second_top,
  input  wire logic [biou_pkg::SIZE_W-1:0]   second_width,
  input  wire logic [biou_pkg::SIZE_W-1:0]   second_height,
  output logic                               out_valid,
  output biou_pkg::biou_area_t               out_area
);
  import biou_pkg::*;

  // stage 1: clamped overlap extents
  logic signed [EDGE_W-1:0] r1, r2, b1, b2, l1, l2, t1, t2;
  logic signed [EDGE_W-1:0] rmin, lmax, bmin, tmax;
  logic signed [DIFF_W-1:0] dx, dy;
  logic [EXT_W-1:0]  ix_next, iy_next;

  always_comb begin
    l1 = EDGE_W'($signed(first_left));
    t1 = EDGE_W'($signed(first_top));
    l2 = EDGE_W'($signed(second_left));
    t2 = EDGE_W'($signed(second_top));
    r1 = l1 + $signed({2'b00, first_width});
    b1 = t1 + $signed({2'b00, first_height});
    r2 = l2 + $signed({2'b00, second_width});
    b2 = t2 + $signed({2'b00, second_height});
    rmin = (r1 < r2) ? r1 : r2;
    lmax = (l1 > l2) ? l1 : l2;
    bmin = (b1 < b2) ? b1 : b2;
    tmax = (t1 > t2) ? t1 : t2;
    dx = DIFF_W'(rmin) - DIFF_W'(lmax);
    dy = DIFF_W'(bmin) - DIFF_W'(tmax);
    // a positive extent never exceeds the smaller size, so it fits EXT_W
    ix_next = (dx > 0) ? dx[EXT_W-1:0] : '0;
    iy_next = (dy > 0) ? dy[EXT_W-1:0] : '0;
  end

  logic              v1;
  logic [EXT_W-1:0]  ix, iy;
  logic [SIZE_W-1:0] w1, h1, w2, h2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    ix <= ix_next;
    iy <= iy_next;
    w1 <= first_width;
    h1 <= first_height;
    w2 <= second_width;
    h2 <= second_height;
  end

  // stage 2: products
  logic              v2;
  logic [AREA_W-1:0] inter, area1, area2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    inter <= AREA_W'(ix) * AREA_W'(iy);
    area1 <= AREA_W'(w1) * AREA_W'(h1);
    area2 <= AREA_W'(w2) * AREA_W'(h2);
  end

  // stage 3: union, never below the intersection
  logic [UNION_W-1:0] uni_next;

  assign uni_next = UNION_W'(area1) + UNION_W'(area2) - UNION_W'(inter);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2;
    end
    out_area.inter <= inter;
    out_area.uni   <= uni_next;
    out_area.empty <= (uni_next == '0);
  end

endmodule

`default_nettype wire

[rtl/biou_div.sv]
// ----------------------------------------------------------------------------
// biou_div - pipelined restoring divider
// One quotient bit per stage: floor(inter * 2^16 / union).
// ----------------------------------------------------------------------------
`default_nettype none

module biou_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire biou_pkg::biou_area_t         in_area,
  output logic                              out_valid,
  output logic [biou_pkg::RATIO_W-1:0]      out_quo,
  output logic                              out_empty
);
  import biou_pkg::*;

  biou_div_t pipe  [DIV_STAGES];
  logic      valid [DIV_STAGES];

  // first stage: integer bit is set only when intersection equals union
  logic first_bit;

  assign first_bit = (UNION_W'(in_area.inter) >= in_area.uni);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else begin
      valid[0] <= in_valid;
    end
    pipe[0].rem   <= first_bit ? UNION_W'(in_area.inter) - in_area.uni
                               : UNION_W'(in_area.inter);
    pipe[0].uni   <= in_area.uni;
    pipe[0].quo   <= RATIO_W'(first_bit);
    pipe[0].empty <= in_area.empty;
  end

  for (genvar s = 1; s < DIV_STAGES; s++) begin : g_step
    logic [SHIFT_W-1:0] shifted;
    logic               ge;
    logic [SHIFT_W-1:0] diff;

    assign shifted = {pipe[s-1].rem, 1'b0};
    assign ge      = (shifted >= {1'b0, pipe[s-1].uni});
    assign diff    = shifted - {1'b0, pipe[s-1].uni};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s] <= 1'b0;
      end else begin
        valid[s] <= valid[s-1];
      end
      // remainder stays below the union, so it fits UNION_W
      pipe[s].rem   <= ge ? diff[UNION_W-1:0] : shifted[UNION_W-1:0];
      pipe[s].uni   <= pipe[s-1].uni;
      pipe[s].quo   <= {pipe[s-1].quo[RATIO_W-2:0], ge};
      pipe[s].empty <= pipe[s-1].empty;
    end
  end

  assign out_valid = valid[DIV_STAGES-1];
  assign out_quo   = pipe[DIV_STAGES-1].quo;
  assign out_empty = pipe[DIV_STAGES-1].empty;

endmodule

`default_nettype wire
